>>> rtl/core/bounded_deque_with_erase_unit_macros.svh
// Assertion macros for the bounded deque unit.
`ifndef BOUNDED_DEQUE_WITH_ERASE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_ERASE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BDQ_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bdq check failed");
`define BDQ_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bdq check failed");
`else
`define BDQ_ASSERT_IMP(label, ck, rn, ante, cons)
`define BDQ_ASSERT_NXT(label, ck, rn, ante, cons)
`endif
`endif

>>> rtl/core/bdq_pkg.sv
// Types and codes shared by the bounded deque unit.
package bdq_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int COUNT_BITS  = 5;
    localparam int ACTION_BITS = 3;
    localparam int STATUS_BITS = 2;

    typedef logic [ACTION_BITS-1:0] action_t;
    typedef logic [STATUS_BITS-1:0] status_t;

    localparam action_t ACT_ADD_BACK  = 3'd0;
    localparam action_t ACT_RMV_BACK  = 3'd1;
    localparam action_t ACT_ADD_FRONT = 3'd2;
    localparam action_t ACT_RMV_FRONT = 3'd3;
    localparam action_t ACT_ERASE     = 3'd4;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_NOTFOUND = 2'd3;

endpackage

>>> rtl/core/bounded_deque_with_erase_unit.sv
// Bounded deque with erase-by-value, kept as a doubly linked list in RAM.
//
// Command channel: a transaction is taken at a rising edge with start high and
// busy low; action and value are sampled there. Every transaction returns one
// result: removed_value, status and entry_count are valid while done is high,
// which is for exactly one cycle. The receiver cannot stall; it must take each
// result in that cycle.
//
// States after the accept edge (the result strobe follows the last of them):
//   full add, empty remove, empty erase, unused action: none, result from IDLE
//   add back / add front:                               ADD1, ADD2
//   remove back / remove front:                         SCAN, UNL1, UNL2
//   erase matching an entry: SCAN walks from the front to it, then UNL1, UNL2
//   erase with no match: SCAN walks the whole list
// Each link RAM has a single write port, so an add or an unlink spreads its
// link writes over ADD1/ADD2 or UNL1/UNL2; the erase walk reads one entry per cycle.
//
// Reset: the list is empty, every entry is free. Entries above the fill mark
// have never been handed out and form an implicit free chain, so no clearing
// pass runs and the block is ready right after reset.
`include "bounded_deque_with_erase_unit_macros.svh"

module bounded_deque_with_erase_unit #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bdq_pkg::action_t                action,
    input  logic [bdq_pkg::VALUE_BITS-1:0]  value,
    output logic                            done,
    output logic [bdq_pkg::VALUE_BITS-1:0]  removed_value,
    output bdq_pkg::status_t                status,
    output logic [bdq_pkg::COUNT_BITS-1:0]  entry_count
);
    import bdq_pkg::*;

    // index width, link width (holds the null code), stored value width
    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int VW = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;

    localparam logic [LW-1:0] NIL     = LW'(CAPACITY);
    localparam logic [LW-1:0] LAST_ST = LW'(CAPACITY - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD1 = 3'd1;
    localparam logic [2:0] S_ADD2 = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_UNL1 = 3'd4;
    localparam logic [2:0] S_UNL2 = 3'd5;

    // entry and link RAMs
    logic [VW-1:0] val_mem  [CAPACITY];
    logic [LW-1:0] next_mem [CAPACITY];
    logic [LW-1:0] prev_mem [CAPACITY];

    logic [IW-1:0] rd_addr;
    logic [VW-1:0] val_rd_reg;
    logic [LW-1:0] next_rd_reg;
    logic [LW-1:0] prev_rd_reg;

    logic          val_we;
    logic [IW-1:0] val_wa;
    logic          next_we;
    logic [IW-1:0] next_wa;
    logic [LW-1:0] next_wd;
    logic          prev_we;
    logic [IW-1:0] prev_wa;
    logic [LW-1:0] prev_wd;

    // sequencer and list state
    logic [2:0]    state_reg, state_next;
    action_t       act_reg, act_next;
    logic [VW-1:0] val_reg, val_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] node_reg, node_next;
    logic [LW-1:0] p_reg, p_next;
    logic [LW-1:0] q_reg, q_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic [VW-1:0] removed_reg, removed_next;
    logic [LW-1:0] front_reg, front_next;
    logic [LW-1:0] back_reg, back_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [LW-1:0] count_reg, count_next;

    // result register
    logic                  done_reg;
    logic [VALUE_BITS-1:0] rv_reg;
    status_t               status_reg;
    logic [COUNT_BITS-1:0] cnt_reg;

    logic          accept;
    logic          fin;
    status_t       fin_status;
    logic [VW-1:0] fin_removed;
    logic [LW-1:0] sel_end;
    logic          hit;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        node_next      = node_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        steps_next     = steps_reg;
        removed_next   = removed_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;

        rd_addr = cur_reg;
        val_we  = 1'b0;
        val_wa  = free_head_reg[IW-1:0];
        next_we = 1'b0;
        next_wa = node_reg;
        next_wd = NIL;
        prev_we = 1'b0;
        prev_wa = node_reg;
        prev_wd = NIL;

        fin         = 1'b0;
        fin_status  = ST_OK;
        fin_removed = '0;
        sel_end     = (action == ACT_RMV_BACK) ? back_reg : front_reg;
        hit         = (act_reg != ACT_ERASE) || (val_rd_reg == val_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action;
                    val_next   = value[VW-1:0];
                    steps_next = '0;
                    unique case (action) inside
                        ACT_ADD_BACK, ACT_ADD_FRONT:
                        begin
                            // fetch the link that follows the free head
                            rd_addr = free_head_reg[IW-1:0];
                            if (count_reg == NIL)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_ADD1;
                            end
                        end
                        ACT_RMV_BACK, ACT_RMV_FRONT, ACT_ERASE:
                        begin
                            rd_addr  = sel_end[IW-1:0];
                            cur_next = sel_end[IW-1:0];
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = (action == ACT_ERASE) ? ST_NOTFOUND : ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD1:
            begin
                node_next = free_head_reg[IW-1:0];
                val_we    = 1'b1;
                next_we   = 1'b1;
                next_wa   = free_head_reg[IW-1:0];
                prev_we   = 1'b1;
                prev_wa   = free_head_reg[IW-1:0];
                if (act_reg == ACT_ADD_BACK)
                begin
                    next_wd = NIL;
                    prev_wd = back_reg;
                end
                else
                begin
                    next_wd = front_reg;
                    prev_wd = NIL;
                end
                // entries at the fill mark were never used: implicit link n+1
                if (free_head_reg == fill_reg)
                begin
                    free_head_next = fill_reg + 1'b1;
                    fill_next      = fill_reg + 1'b1;
                end
                else
                begin
                    free_head_next = next_rd_reg;
                end
                count_next = count_reg + 1'b1;
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                if (act_reg == ACT_ADD_BACK)
                begin
                    if (back_reg != NIL)
                    begin
                        next_we = 1'b1;
                        next_wa = back_reg[IW-1:0];
                        next_wd = LW'(node_reg);
                    end
                    else
                    begin
                        front_next = LW'(node_reg);
                    end
                    back_next = LW'(node_reg);
                end
                else
                begin
                    if (front_reg != NIL)
                    begin
                        prev_we = 1'b1;
                        prev_wa = front_reg[IW-1:0];
                        prev_wd = LW'(node_reg);
                    end
                    else
                    begin
                        back_next = LW'(node_reg);
                    end
                    front_next = LW'(node_reg);
                end
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    removed_next = val_rd_reg;
                    node_next    = cur_reg;
                    p_next       = prev_rd_reg;
                    q_next       = next_rd_reg;
                    state_next   = S_UNL1;
                end
                else if (next_rd_reg == NIL || steps_reg == LAST_ST)
                begin
                    fin        = 1'b1;
                    fin_status = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    // follow the forward link, one entry per cycle
                    cur_next   = next_rd_reg[IW-1:0];
                    rd_addr    = next_rd_reg[IW-1:0];
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_UNL1:
            begin
                if (p_reg != NIL)
                begin
                    next_we = 1'b1;
                    next_wa = p_reg[IW-1:0];
                    next_wd = q_reg;
                end
                else
                begin
                    front_next = q_reg;
                end
                if (q_reg != NIL)
                begin
                    prev_we = 1'b1;
                    prev_wa = q_reg[IW-1:0];
                    prev_wd = p_reg;
                end
                else
                begin
                    back_next = p_reg;
                end
                state_next = S_UNL2;
            end
            S_UNL2:
            begin
                // push the freed entry onto the free chain
                next_we        = 1'b1;
                next_wa        = node_reg;
                next_wd        = free_head_reg;
                free_head_next = LW'(node_reg);
                count_next     = count_reg - 1'b1;
                fin            = 1'b1;
                fin_removed    = removed_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= NIL;
            back_reg      <= NIL;
            free_head_reg <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            done_reg      <= fin;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        val_reg     <= val_next;
        cur_reg     <= cur_next;
        node_reg    <= node_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        steps_reg   <= steps_next;
        removed_reg <= removed_next;
        if (fin)
        begin
            rv_reg     <= VALUE_BITS'(fin_removed);
            status_reg <= fin_status;
            cnt_reg    <= COUNT_BITS'(count_next);
        end
    end

    // RAMs: one write port each, shared registered read address
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_wa] <= val_reg;
        end
        val_rd_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd_reg <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_rd_reg <= prev_mem[rd_addr];
    end

    assign done          = done_reg;
    assign removed_value = rv_reg;
    assign status        = status_reg;
    assign entry_count   = cnt_reg;

    `BDQ_ASSERT_IMP(a_empty, clk, rst_n, count_reg == '0, front_reg == NIL && back_reg == NIL)
    `BDQ_ASSERT_IMP(a_free, clk, rst_n, count_reg != NIL, free_head_reg != NIL)
    `BDQ_ASSERT_NXT(a_unlink, clk, rst_n, state_reg == S_UNL2, done && status == ST_OK)
    `BDQ_ASSERT_NXT(a_full, clk, rst_n, accept && count_reg == NIL && action == ACT_ADD_BACK, done)

endmodule
